// File: hdl/tep_pkg.sv
`timescale 1ns / 1ps

package tep_pkg;

    localparam int MOUSE_GUARD = 32;
    localparam int CSI_GUARD   = 8;
    localparam int COORD_WIDTH = 16;

    localparam int CNT_W      = 6;
    localparam int ACC_W      = COORD_WIDTH + 1;
    localparam int PROD_W     = ACC_W + 4;
    localparam int OUT_W      = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_M   = 8'h4D;
    localparam logic [7:0] CH_UP_O   = 8'h4F;
    localparam logic [7:0] CH_UP_P   = 8'h50;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_M   = 8'h6D;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_FKEY,
        KIND_BACKTAB,
        KIND_MOUSE,
        KIND_BAD_MOUSE,
        KIND_ESCAPE
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC1,
        PH_ESC2,
        PH_CSI,
        PH_MOUSE
    } t_phase;

    typedef enum logic [1:0] {
        FP_START,
        FP_SIGN,
        FP_DIGITS
    } t_field_phase;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       empty_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       key_byte;
        logic [3:0]       fkey_number;
        logic [OUT_W-1:0] mouse_x;
        logic [OUT_W-1:0] mouse_y;
        logic             released;
        logic             esc_parsed;
        logic             last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
    endfunction

    function automatic logic [3:0] csi_key(input logic [7:0] first, input logic [7:0] second);
        logic [7:0] diff;
        diff = 8'h00;
        if (first == CH_ONE) begin
            if ((second >= CH_ONE) && (second <= CH_FIVE)) begin
                diff = second - CH_ZERO;
            end else if ((second >= CH_SEVEN) && (second <= CH_NINE)) begin
                diff = second - CH_ONE;
            end
        end else if (first == CH_TWO) begin
            if (second == CH_ZERO) begin
                diff = 8'd9;
            end else if (second == CH_ONE) begin
                diff = 8'd10;
            end
        end
        return diff[3:0];
    endfunction

    function automatic logic [OUT_W-1:0] coord(input logic [ACC_W-1:0] mag, input logic neg);
        logic [ACC_W-1:0] dec;
        dec = mag - ACC_W'(1);
        if (neg || (mag == '0)) begin
            return '0;
        end
        return OUT_W'(dec[COORD_WIDTH-1:0]);
    endfunction

    function automatic t_result make_result(input t_kind kind, input logic [7:0] key,
                                            input logic [3:0] fk,
                                            input logic [OUT_W-1:0] x,
                                            input logic [OUT_W-1:0] y,
                                            input logic rel, input logic pe,
                                            input logic last);
        t_result r;
        r.kind        = kind;
        r.key_byte    = key;
        r.fkey_number = fk;
        r.mouse_x     = x;
        r.mouse_y     = y;
        r.released    = rel;
        r.esc_parsed  = pe;
        r.last        = last;
        return r;
    endfunction

endpackage

// File: hdl/terminal_escape_input_parser.sv
`timescale 1ns / 1ps

// Parses one terminal byte, or one empty marker, in every cycle in which the input transfer
// completes, and places the zero, one or two results it causes into a four-entry result queue
// in the same cycle; the output reads each result from the queue's registered storage. The
// input stalls while fewer than two queue entries are free, so an empty marker that yields two
// results (a timed-out escape and the held byte as a plain key) never waits inside the parser,
// and while the output takes a result each cycle and two entries stay free, one byte is consumed per cycle.
module terminal_escape_input_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tep_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tep_pkg::t_result  o_out_data
);
    import tep_pkg::*;

    logic       w_accept;
    logic       w_pop;
    logic [1:0] w_res_cnt;
    logic [1:0] w_push_cnt;
    t_result    w_res0;
    t_result    w_res1;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pop      = o_out_valid && !i_out_stall;
    assign w_push_cnt = w_accept ? w_res_cnt : 2'd0;

    tep_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (i_in_data),
        .o_res0    (w_res0),
        .o_res1    (w_res1),
        .o_res_cnt (w_res_cnt)
    );

    tep_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_pop      (w_pop),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .o_stall    (o_in_stall)
    );

endmodule

// File: hdl/tep_parser.sv
`timescale 1ns / 1ps

module tep_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tep_pkg::t_in_item i_item,
    output tep_pkg::t_result  o_res0,
    output tep_pkg::t_result  o_res1,
    output logic [1:0]        o_res_cnt
);
    import tep_pkg::*;

    t_phase             r_phase, n_phase;
    logic [7:0]         r_held, n_held;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [1:0]         r_field_idx, n_field_idx;
    t_field_phase       r_field_ph, n_field_ph;
    logic               r_neg_x, n_neg_x;
    logic               r_neg_y, n_neg_y;
    logic [1:0]         r_btn, n_btn;
    logic [ACC_W-1:0]   r_x, n_x;
    logic [ACC_W-1:0]   r_y, n_y;
    logic               r_bad, n_bad;
    logic [7:0]         r_first, n_first;
    logic [7:0]         r_second, n_second;

    logic               w_empty;
    logic [7:0]         w_b;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic               w_csi_done;
    logic               w_mouse_final;
    logic [3:0]         w_digit;
    logic [PROD_W-1:0]  w_acc_sel;
    logic [PROD_W-1:0]  w_prod;
    logic [ACC_W-1:0]   w_acc_new;
    logic [3:0]         w_fk;
    logic               w_mouse_ok;

    localparam logic [PROD_W-1:0] ACC_CAP = PROD_W'(1) << COORD_WIDTH;

    assign w_empty       = i_item.empty_req;
    assign w_b           = i_item.byte_in;
    assign w_cnt_inc     = r_count + CNT_W'(1);
    assign w_digit       = w_b[3:0];
    assign w_mouse_final = (w_b == CH_UP_M) || (w_b == CH_LO_M);
    assign w_csi_done    = w_empty || (w_b == CH_TILDE) || is_alpha(w_b)
                           || (w_cnt_inc >= CNT_W'(CSI_GUARD));
    assign w_fk          = (!w_empty && (w_b == CH_TILDE) && (w_cnt_inc == CNT_W'(2)))
                           ? csi_key(r_first, r_second) : 4'd0;
    assign w_mouse_ok    = !r_bad && ((r_field_idx == 2'd3)
                           || ((r_field_idx == 2'd2) && (r_field_ph == FP_DIGITS)));

    // Decimal accumulation with saturation one above the largest coordinate.
    assign w_acc_sel = (r_field_idx == 2'd1) ? PROD_W'(r_x) : PROD_W'(r_y);
    assign w_prod    = (w_acc_sel << 3) + (w_acc_sel << 1) + PROD_W'(w_digit);
    assign w_acc_new = (w_prod > ACC_CAP) ? ACC_W'(ACC_CAP) : w_prod[ACC_W-1:0];

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (!w_empty && (w_b == CH_ESC)) begin
                    n_phase = PH_ESC1;
                end
            end
            PH_ESC1: begin
                n_phase = w_empty ? PH_IDLE : PH_ESC2;
            end
            PH_ESC2: begin
                if (w_empty) begin
                    n_phase = (r_held == CH_ESC) ? PH_ESC1 : PH_IDLE;
                end else if ((r_held == CH_LBRACK) && (w_b == CH_LT)) begin
                    n_phase = PH_MOUSE;
                end else if ((r_held == CH_LBRACK) && is_digit(w_b)
                             && !(w_b == CH_UP_Z)) begin
                    n_phase = PH_CSI;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CSI: begin
                if (w_csi_done) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_MOUSE: begin
                if (w_empty || w_mouse_final || (w_cnt_inc >= CNT_W'(MOUSE_GUARD))) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_held      = r_held;
        n_count     = r_count;
        n_field_idx = r_field_idx;
        n_field_ph  = r_field_ph;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_btn       = r_btn;
        n_x         = r_x;
        n_y         = r_y;
        n_bad       = r_bad;
        n_first     = r_first;
        n_second    = r_second;
        o_res0      = '0;
        o_res1      = '0;
        o_res_cnt   = 2'd0;
        case (r_phase)
            PH_IDLE: begin
                if (!w_empty && (w_b != CH_ESC)) begin
                    o_res0    = make_result(KIND_PLAIN, w_b, 4'd0, '0, '0, 1'b0, 1'b0, 1'b1);
                    o_res_cnt = 2'd1;
                end
            end
            PH_ESC1: begin
                if (w_empty) begin
                    o_res0    = make_result(KIND_ESCAPE, 8'd0, 4'd0, '0, '0, 1'b0, 1'b0, 1'b1);
                    o_res_cnt = 2'd1;
                end else begin
                    n_held = w_b;
                end
            end
            PH_ESC2: begin
                if (w_empty) begin
                    o_res0 = make_result(KIND_ESCAPE, 8'd0, 4'd0, '0, '0, 1'b0, 1'b0,
                                         r_held == CH_ESC);
                    if (r_held == CH_ESC) begin
                        o_res_cnt = 2'd1;
                    end else begin
                        o_res1    = make_result(KIND_PLAIN, r_held, 4'd0, '0, '0,
                                                1'b0, 1'b0, 1'b1);
                        o_res_cnt = 2'd2;
                    end
                end else if ((r_held == CH_LBRACK) && (w_b == CH_LT)) begin
                    n_count     = '0;
                    n_field_idx = 2'd0;
                    n_field_ph  = FP_START;
                    n_neg_x     = 1'b0;
                    n_neg_y     = 1'b0;
                    n_btn       = 2'd0;
                    n_x         = '0;
                    n_y         = '0;
                    n_bad       = 1'b0;
                end else if ((r_held == CH_UP_O) && (w_b >= CH_UP_P) && (w_b <= CH_UP_S)) begin
                    o_res0    = make_result(KIND_FKEY, 8'd0, w_b[3:0] + 4'd1, '0, '0,
                                            1'b0, 1'b1, 1'b1);
                    o_res_cnt = 2'd1;
                end else if ((r_held == CH_LBRACK) && (w_b == CH_UP_Z)) begin
                    o_res0    = make_result(KIND_BACKTAB, 8'd0, 4'd0, '0, '0, 1'b0, 1'b1, 1'b1);
                    o_res_cnt = 2'd1;
                end else if ((r_held == CH_LBRACK) && is_digit(w_b)) begin
                    n_first  = w_b;
                    n_second = 8'd0;
                    n_count  = '0;
                end else begin
                    o_res0    = make_result(KIND_ESCAPE, 8'd0, 4'd0, '0, '0, 1'b0, 1'b1, 1'b1);
                    o_res_cnt = 2'd1;
                end
            end
            PH_CSI: begin
                if (!w_empty) begin
                    n_count = w_cnt_inc;
                    if (w_cnt_inc == CNT_W'(1)) begin
                        n_second = w_b;
                    end
                end
                if (w_csi_done) begin
                    if (w_fk != 4'd0) begin
                        o_res0 = make_result(KIND_FKEY, 8'd0, w_fk, '0, '0, 1'b0, 1'b1, 1'b1);
                    end else begin
                        o_res0 = make_result(KIND_ESCAPE, 8'd0, 4'd0, '0, '0, 1'b0, 1'b1, 1'b1);
                    end
                    o_res_cnt = 2'd1;
                end
            end
            PH_MOUSE: begin
                if (w_empty) begin
                    o_res0    = make_result(KIND_BAD_MOUSE, 8'd0, 4'd0, '0, '0, 1'b0, 1'b1, 1'b1);
                    o_res_cnt = 2'd1;
                end else if (w_mouse_final) begin
                    if (w_mouse_ok) begin
                        o_res0 = make_result(KIND_MOUSE, 8'd0, 4'd0, coord(r_x, r_neg_x),
                                             coord(r_y, r_neg_y),
                                             (w_b == CH_LO_M) && (r_btn == 2'd0),
                                             1'b1, 1'b1);
                    end else begin
                        o_res0 = make_result(KIND_BAD_MOUSE, 8'd0, 4'd0, '0, '0,
                                             1'b0, 1'b1, 1'b1);
                    end
                    o_res_cnt = 2'd1;
                end else begin
                    if (!r_bad && (r_field_idx != 2'd3)) begin
                        if (w_b == CH_NUL) begin
                            if ((r_field_idx == 2'd2) && (r_field_ph == FP_DIGITS)) begin
                                n_field_idx = 2'd3;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end else if ((r_field_ph == FP_START) && ((w_b == CH_SPACE)
                                     || (w_b inside {[CH_TAB:CH_CR]}))) begin
                            n_bad = r_bad;
                        end else if ((r_field_ph == FP_START)
                                     && ((w_b == CH_PLUS) || (w_b == CH_MINUS))) begin
                            n_field_ph = FP_SIGN;
                            if (w_b == CH_MINUS) begin
                                if (r_field_idx == 2'd1) begin
                                    n_neg_x = 1'b1;
                                end else if (r_field_idx == 2'd2) begin
                                    n_neg_y = 1'b1;
                                end
                            end
                        end else if (is_digit(w_b)) begin
                            n_field_ph = FP_DIGITS;
                            if (r_field_idx == 2'd0) begin
                                n_btn = {r_btn[0], 1'b0} + w_digit[1:0];
                            end else if (r_field_idx == 2'd1) begin
                                n_x = w_acc_new;
                            end else begin
                                n_y = w_acc_new;
                            end
                        end else if ((r_field_ph == FP_DIGITS) && (r_field_idx != 2'd2)
                                     && (w_b == CH_SEMI)) begin
                            n_field_idx = r_field_idx + 2'd1;
                            n_field_ph  = FP_START;
                        end else if ((r_field_ph == FP_DIGITS) && (r_field_idx == 2'd2)) begin
                            n_field_idx = 2'd3;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    n_count = w_cnt_inc;
                    if (w_cnt_inc >= CNT_W'(MOUSE_GUARD)) begin
                        o_res0    = make_result(KIND_BAD_MOUSE, 8'd0, 4'd0, '0, '0,
                                                1'b0, 1'b1, 1'b1);
                        o_res_cnt = 2'd1;
                    end
                end
            end
            default: begin
                o_res_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_held      <= 8'd0;
            r_count     <= '0;
            r_field_idx <= 2'd0;
            r_field_ph  <= FP_START;
            r_neg_x     <= 1'b0;
            r_neg_y     <= 1'b0;
            r_btn       <= 2'd0;
            r_x         <= '0;
            r_y         <= '0;
            r_bad       <= 1'b0;
            r_first     <= 8'd0;
            r_second    <= 8'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_count     <= n_count;
            r_field_idx <= n_field_idx;
            r_field_ph  <= n_field_ph;
            r_neg_x     <= n_neg_x;
            r_neg_y     <= n_neg_y;
            r_btn       <= n_btn;
            r_x         <= n_x;
            r_y         <= n_y;
            r_bad       <= n_bad;
            r_first     <= n_first;
            r_second    <= n_second;
        end
    end

`ifndef ASSERT_OFF
    a_csi_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CSI) |-> (r_count < CNT_W'(CSI_GUARD)))
        else $error("sequence byte count passed its guard");

    a_mouse_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MOUSE) |-> (r_count < CNT_W'(MOUSE_GUARD)))
        else $error("mouse report byte count passed its guard");

    a_field_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_field_idx == 2'd3) |-> (r_field_ph == FP_DIGITS))
        else $error("mouse report closed without a final number");
`endif

endmodule

// File: hdl/tep_result_fifo.sv
`timescale 1ns / 1ps

module tep_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  tep_pkg::t_result i_res0,
    input  tep_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_valid,
    output tep_pkg::t_result o_data,
    output logic             o_stall
);
    import tep_pkg::*;

    localparam int CNT_BITS = FIFO_AW + 1;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [FIFO_AW-1:0]    w_wr_next;

    assign w_wr_next = r_wr_ptr + FIFO_AW'(1);
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign o_stall   = (r_count > CNT_BITS'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push_cnt);
        n_rd_ptr = i_pop ? (r_rd_ptr + FIFO_AW'(1)) : r_rd_ptr;
        n_count  = r_count + CNT_BITS'(i_push_cnt) - CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_push_cnt == 2'd0))
        else $error("results written while the queue lacked room for two");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(FIFO_DEPTH))
        else $error("result queue count beyond its depth");
`endif

endmodule
